// ===== rtl/core/mips_subset_execute_unit_assert.svh =====
// Assertion macros used by the execute unit port checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MIPS_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define MSEU_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define MSEU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mseu_pkg.sv =====
// Shared types and constants for the MIPS subset execute unit.
// Used by the top level and by its port checker; depends on nothing.
package mseu_pkg;

    localparam int DATA_W    = 32;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;
    localparam int TARGET_W  = 10;
    localparam int OUT_LINE_W = 10;

    // power of two: line numbers wrap by keeping the low bits
    localparam int PROGRAM_LINES = 1024;

    localparam logic [REG_AW-1:0] LINK_REG  = 5'd31;
    localparam logic [REG_AW-1:0] ZERO_REG  = 5'd0;
    localparam logic [4:0]        ITER_LAST = 5'd31;

    // Input item layout, lowest bit first
    localparam int IN_TDATA_W     = 64;
    localparam int IN_ACTION_LSB  = 0;
    localparam int IN_DEST_LSB    = 4;
    localparam int IN_SRC_A_LSB   = 9;
    localparam int IN_SRC_B_LSB   = 14;
    localparam int IN_IMM_LSB     = 19;
    localparam int IN_TARGET_LSB  = 51;

    // Result item layout, lowest bit first
    localparam int OUT_TDATA_W    = 56;
    localparam int OUT_LINE_LSB   = 0;
    localparam int OUT_WE_BIT     = 10;
    localparam int OUT_WREG_LSB   = 11;
    localparam int OUT_WVAL_LSB   = 16;
    localparam int OUT_TAKEN_BIT  = 48;
    localparam int OUT_DZ_BIT     = 49;
    localparam int OUT_PAD_W      = 6;

    typedef enum logic [3:0] {
        ACT_ADDI = 4'd0,
        ACT_SUBI = 4'd1,
        ACT_ADD  = 4'd2,
        ACT_SUB  = 4'd3,
        ACT_MUL  = 4'd4,
        ACT_DIV  = 4'd5,
        ACT_BLT  = 4'd6,
        ACT_BGT  = 4'd7,
        ACT_BEQ  = 4'd8,
        ACT_J    = 4'd9,
        ACT_JAL  = 4'd10,
        ACT_JR   = 4'd11
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ_A,
        S_READ_B,
        S_READ_D,
        S_DECODE,
        S_ALU,
        S_MUL,
        S_NEG_A,
        S_NEG_B,
        S_DIV,
        S_FIX,
        S_CMP,
        S_TGT,
        S_DONE
    } state_t;

endpackage

// ===== rtl/core/mips_subset_execute_unit.sv =====
// MIPS subset execute unit: register file, program counter, sequencer and one
// shared 33-bit adder. Depends on mseu_pkg.
//
// One decoded instruction enters per item and leaves one result item. The unit
// reads its three source registers one after another through the single read
// port of the register file, then runs the work through one 33-bit adder/
// subtractor: add, sub, addi, subi and compares take one pass, mul 32 shift-add
// passes, div two negate passes, 32 restoring steps and a sign fix. Div by
// zero and unused action codes go from decode straight to the result; result
// back-pressure holds a finished item until the output register is free.
// Line numbers wrap by keeping the low bits of a target or jr value.
// The input side is not ready while an item is in flight; a finished result
// sits in the output register so the next item can be taken while it waits.
// Register zero reads as 0 and is never written.
module mips_subset_execute_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // action[3:0], dest_reg[8:4], src_a_reg[13:9], src_b_reg[18:14],
    // immediate[50:19], jump_target[60:51], zero pad[63:61]
    input  logic [mseu_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // next_line[9:0], write_enable[10], written_reg[15:11],
    // written_value[47:16], branch_taken[48], divide_by_zero[49], zero pad[55:50]
    output logic [mseu_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int LINE_W = $clog2(mseu_pkg::PROGRAM_LINES);
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(mseu_pkg::PROGRAM_LINES - 1);

    mseu_pkg::state_t state_reg;
    mseu_pkg::state_t state_next;

    // captured item fields
    mseu_pkg::action_t              action_reg;
    logic [mseu_pkg::REG_AW-1:0]    dest_idx_reg;
    logic [mseu_pkg::REG_AW-1:0]    src_a_idx_reg;
    logic [mseu_pkg::REG_AW-1:0]    src_b_idx_reg;
    logic [mseu_pkg::DATA_W-1:0]    imm_reg;
    logic [mseu_pkg::TARGET_W-1:0]  target_reg;

    // working registers
    logic [31:0] a_val_reg, a_val_next;
    logic [31:0] b_val_reg, b_val_next;
    logic [31:0] d_val_reg, d_val_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] y_reg, y_next;
    logic [31:0] wval_reg, wval_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_q_reg, neg_q_next;
    logic        we_reg, we_next;
    logic        taken_reg, taken_next;
    logic        dz_reg, dz_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [LINE_W-1:0] prog_line_reg, prog_line_next;
    logic [LINE_W-1:0] seq_line;

    // register file
    logic [31:0]                  rf_mem [mseu_pkg::REG_COUNT];
    logic [mseu_pkg::REG_COUNT-1:0] rf_valid_reg;
    logic [mseu_pkg::REG_AW-1:0]  rf_raddr;
    logic [mseu_pkg::REG_AW-1:0]  rf_waddr;
    logic                         rf_we;
    logic [31:0]                  rf_wdata;
    logic [31:0]                  rf_rdata_reg;
    logic                         rf_rvalid_reg;
    logic [31:0]                  rd_operand;

    // output stage
    logic                           m_tvalid_reg;
    logic [mseu_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                           out_free;
    logic                           out_load;
    logic                           in_accept;

    // shared adder
    logic [32:0] add_a, add_b, add_sum;
    logic        add_sub;

    logic [31:0] rem_shift;
    logic        div_fit;
    logic [31:0] acc_div;
    logic [31:0] y_div;
    logic [31:0] acc_mul;
    logic        cmp_lt, cmp_eq, cmp_hit;
    logic        iter_done;
    logic [mseu_pkg::REG_AW-1:0] wreg_idx;
    logic        commit_we;

    assign s_tready  = (state_reg == mseu_pkg::S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign rd_operand = rf_rvalid_reg ? rf_rdata_reg : 32'd0;
    assign seq_line   = (prog_line_reg == LAST_LINE) ? '0 : prog_line_reg + LINE_W'(1);
    assign iter_done  = (cnt_reg == mseu_pkg::ITER_LAST);

    // restoring divide step: shift in the next dividend bit, try the subtract
    assign rem_shift = {acc_reg[30:0], y_reg[31]};
    assign div_fit   = !add_sum[32];
    assign acc_div   = div_fit ? add_sum[31:0] : rem_shift;
    assign y_div     = {y_reg[30:0], div_fit};
    assign acc_mul   = y_reg[0] ? add_sum[31:0] : acc_reg;

    assign cmp_lt = add_sum[32];
    assign cmp_eq = (add_sum == 33'd0);

    assign wreg_idx  = (action_reg == mseu_pkg::ACT_JAL) ? mseu_pkg::LINK_REG : dest_idx_reg;
    assign commit_we = we_reg && (wreg_idx != mseu_pkg::ZERO_REG);

    always_comb
    begin
        unique case (action_reg)
            mseu_pkg::ACT_BLT: cmp_hit = cmp_lt;
            mseu_pkg::ACT_BGT: cmp_hit = !cmp_lt && !cmp_eq;
            mseu_pkg::ACT_BEQ: cmp_hit = cmp_eq;
            default:           cmp_hit = 1'b0;
        endcase
    end

    // operand selection for the shared adder
    always_comb
    begin
        add_a   = 33'd0;
        add_b   = 33'd0;
        add_sub = 1'b0;
        unique case (state_reg)
            mseu_pkg::S_ALU:
            begin
                add_a = {1'b0, a_val_reg};
                unique case (action_reg)
                    mseu_pkg::ACT_ADDI:
                    begin
                        add_b = {1'b0, imm_reg};
                    end
                    mseu_pkg::ACT_SUBI:
                    begin
                        add_b   = {1'b0, imm_reg};
                        add_sub = 1'b1;
                    end
                    mseu_pkg::ACT_SUB:
                    begin
                        add_b   = {1'b0, b_val_reg};
                        add_sub = 1'b1;
                    end
                    default:
                    begin
                        add_b = {1'b0, b_val_reg};
                    end
                endcase
            end
            mseu_pkg::S_CMP:
            begin
                // sign-extended so bit 32 is the signed less-than
                add_a   = {d_val_reg[31], d_val_reg};
                add_b   = {a_val_reg[31], a_val_reg};
                add_sub = 1'b1;
            end
            mseu_pkg::S_MUL:
            begin
                add_a = {1'b0, acc_reg};
                add_b = {1'b0, x_reg};
            end
            mseu_pkg::S_NEG_A:
            begin
                add_b   = {1'b0, a_val_reg};
                add_sub = 1'b1;
            end
            mseu_pkg::S_NEG_B:
            begin
                add_b   = {1'b0, b_val_reg};
                add_sub = 1'b1;
            end
            mseu_pkg::S_DIV:
            begin
                add_a   = {1'b0, rem_shift};
                add_b   = {1'b0, x_reg};
                add_sub = 1'b1;
            end
            mseu_pkg::S_FIX:
            begin
                add_b   = {1'b0, y_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                add_a = 33'd0;
            end
        endcase
    end

    assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mseu_pkg::S_IDLE:
            begin
                if (in_accept)
                    state_next = mseu_pkg::S_READ_A;
            end
            mseu_pkg::S_READ_A: state_next = mseu_pkg::S_READ_B;
            mseu_pkg::S_READ_B: state_next = mseu_pkg::S_READ_D;
            mseu_pkg::S_READ_D: state_next = mseu_pkg::S_DECODE;
            mseu_pkg::S_DECODE:
            begin
                unique case (action_reg)
                    mseu_pkg::ACT_ADDI,
                    mseu_pkg::ACT_SUBI,
                    mseu_pkg::ACT_ADD,
                    mseu_pkg::ACT_SUB:  state_next = mseu_pkg::S_ALU;
                    mseu_pkg::ACT_MUL:  state_next = mseu_pkg::S_MUL;
                    mseu_pkg::ACT_DIV:
                    begin
                        if (b_val_reg == 32'd0)
                            state_next = mseu_pkg::S_DONE;
                        else
                            state_next = mseu_pkg::S_NEG_A;
                    end
                    mseu_pkg::ACT_BLT,
                    mseu_pkg::ACT_BGT,
                    mseu_pkg::ACT_BEQ:  state_next = mseu_pkg::S_CMP;
                    mseu_pkg::ACT_J,
                    mseu_pkg::ACT_JAL,
                    mseu_pkg::ACT_JR:   state_next = mseu_pkg::S_TGT;
                    default:            state_next = mseu_pkg::S_DONE;
                endcase
            end
            mseu_pkg::S_ALU:   state_next = mseu_pkg::S_DONE;
            mseu_pkg::S_MUL:
            begin
                if (iter_done)
                    state_next = mseu_pkg::S_DONE;
            end
            mseu_pkg::S_NEG_A: state_next = mseu_pkg::S_NEG_B;
            mseu_pkg::S_NEG_B: state_next = mseu_pkg::S_DIV;
            mseu_pkg::S_DIV:
            begin
                if (iter_done)
                    state_next = mseu_pkg::S_FIX;
            end
            mseu_pkg::S_FIX:   state_next = mseu_pkg::S_DONE;
            mseu_pkg::S_CMP:
            begin
                state_next = cmp_hit ? mseu_pkg::S_TGT : mseu_pkg::S_DONE;
            end
            mseu_pkg::S_TGT:   state_next = mseu_pkg::S_DONE;
            mseu_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = mseu_pkg::S_IDLE;
            end
            default:           state_next = mseu_pkg::S_IDLE;
        endcase
    end

    // datapath controls and working register updates
    always_comb
    begin
        a_val_next     = a_val_reg;
        b_val_next     = b_val_reg;
        d_val_next     = d_val_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        wval_next      = wval_reg;
        cnt_next       = cnt_reg;
        neg_q_next     = neg_q_reg;
        we_next        = we_reg;
        taken_next     = taken_reg;
        dz_next        = dz_reg;
        line_next      = line_reg;
        prog_line_next = prog_line_reg;
        rf_raddr       = dest_idx_reg;
        rf_we          = 1'b0;
        rf_waddr       = wreg_idx;
        rf_wdata       = wval_reg;
        out_load       = 1'b0;
        m_tdata_next   = {mseu_pkg::OUT_PAD_W'(0), dz_reg, taken_reg,
                          commit_we ? wval_reg : 32'd0,
                          commit_we ? wreg_idx : mseu_pkg::ZERO_REG,
                          commit_we, mseu_pkg::OUT_LINE_W'(line_reg)};
        unique case (state_reg)
            mseu_pkg::S_READ_A:
            begin
                rf_raddr = src_a_idx_reg;
            end
            mseu_pkg::S_READ_B:
            begin
                rf_raddr   = src_b_idx_reg;
                a_val_next = rd_operand;
            end
            mseu_pkg::S_READ_D:
            begin
                rf_raddr   = dest_idx_reg;
                b_val_next = rd_operand;
            end
            mseu_pkg::S_DECODE:
            begin
                d_val_next = rd_operand;
                we_next    = 1'b0;
                taken_next = 1'b0;
                dz_next    = 1'b0;
                wval_next  = 32'd0;
                line_next  = seq_line;
                unique case (action_reg)
                    mseu_pkg::ACT_ADDI,
                    mseu_pkg::ACT_SUBI,
                    mseu_pkg::ACT_ADD,
                    mseu_pkg::ACT_SUB:
                    begin
                        we_next = 1'b1;
                    end
                    mseu_pkg::ACT_MUL:
                    begin
                        we_next  = 1'b1;
                        acc_next = 32'd0;
                        x_next   = a_val_reg;
                        y_next   = b_val_reg;
                        cnt_next = 5'd0;
                    end
                    mseu_pkg::ACT_DIV:
                    begin
                        we_next    = 1'b1;
                        dz_next    = (b_val_reg == 32'd0);
                        neg_q_next = a_val_reg[31] ^ b_val_reg[31];
                    end
                    mseu_pkg::ACT_BLT,
                    mseu_pkg::ACT_BGT,
                    mseu_pkg::ACT_BEQ,
                    mseu_pkg::ACT_J:
                    begin
                        taken_next = (action_reg == mseu_pkg::ACT_J);
                        y_next     = 32'(target_reg);
                    end
                    mseu_pkg::ACT_JAL:
                    begin
                        taken_next = 1'b1;
                        we_next    = 1'b1;
                        wval_next  = 32'(seq_line);
                        y_next     = 32'(target_reg);
                    end
                    mseu_pkg::ACT_JR:
                    begin
                        taken_next = 1'b1;
                        y_next     = rd_operand;
                    end
                    default:
                    begin
                        we_next = 1'b0;
                    end
                endcase
            end
            mseu_pkg::S_ALU:
            begin
                wval_next = add_sum[31:0];
            end
            mseu_pkg::S_MUL:
            begin
                acc_next = acc_mul;
                x_next   = {x_reg[30:0], 1'b0};
                y_next   = {1'b0, y_reg[31:1]};
                cnt_next = cnt_reg + 5'd1;
                if (iter_done)
                    wval_next = acc_mul;
            end
            mseu_pkg::S_NEG_A:
            begin
                y_next = a_val_reg[31] ? add_sum[31:0] : a_val_reg;
            end
            mseu_pkg::S_NEG_B:
            begin
                x_next   = b_val_reg[31] ? add_sum[31:0] : b_val_reg;
                acc_next = 32'd0;
                cnt_next = 5'd0;
            end
            mseu_pkg::S_DIV:
            begin
                acc_next = acc_div;
                y_next   = y_div;
                cnt_next = cnt_reg + 5'd1;
            end
            mseu_pkg::S_FIX:
            begin
                wval_next = neg_q_reg ? add_sum[31:0] : y_reg;
            end
            mseu_pkg::S_CMP:
            begin
                taken_next = cmp_hit;
            end
            mseu_pkg::S_TGT:
            begin
                // line count is a power of two: the low bits are the wrapped line
                line_next = y_reg[LINE_W-1:0];
            end
            mseu_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    rf_we          = commit_we;
                    prog_line_next = line_reg;
                end
            end
            default:
            begin
                rf_raddr = dest_idx_reg;
            end
        endcase
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg    <= mseu_pkg::action_t'(s_tdata[mseu_pkg::IN_ACTION_LSB +: 4]);
            dest_idx_reg  <= s_tdata[mseu_pkg::IN_DEST_LSB +: mseu_pkg::REG_AW];
            src_a_idx_reg <= s_tdata[mseu_pkg::IN_SRC_A_LSB +: mseu_pkg::REG_AW];
            src_b_idx_reg <= s_tdata[mseu_pkg::IN_SRC_B_LSB +: mseu_pkg::REG_AW];
            imm_reg       <= s_tdata[mseu_pkg::IN_IMM_LSB +: mseu_pkg::DATA_W];
            target_reg    <= s_tdata[mseu_pkg::IN_TARGET_LSB +: mseu_pkg::TARGET_W];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        a_val_reg <= a_val_next;
        b_val_reg <= b_val_next;
        d_val_reg <= d_val_next;
        acc_reg   <= acc_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        wval_reg  <= wval_next;
        cnt_reg   <= cnt_next;
        neg_q_reg <= neg_q_next;
        we_reg    <= we_next;
        taken_reg <= taken_next;
        dz_reg    <= dz_next;
        line_reg  <= line_next;
        if (out_load)
            m_tdata_reg <= m_tdata_next;
    end

    // register file storage with registered read
    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[rf_waddr] <= rf_wdata;
        rf_rdata_reg <= rf_mem[rf_raddr];
    end

    // entries not yet written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg  <= '0;
            rf_rvalid_reg <= 1'b0;
        end
        else
        begin
            if (rf_we)
                rf_valid_reg[rf_waddr] <= 1'b1;
            rf_rvalid_reg <= rf_valid_reg[rf_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mseu_pkg::S_IDLE;
            prog_line_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prog_line_reg <= prog_line_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/mseu_checker.sv =====
// Port-level checker for the MIPS subset execute unit, bound to the top level.
// Depends on mseu_pkg and mips_subset_execute_unit_assert.svh.
`include "mips_subset_execute_unit_assert.svh"

module mseu_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [mseu_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mseu_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic in_item;
    logic out_we;

    assign in_item = s_tvalid && s_tready && (s_tdata[mseu_pkg::IN_ACTION_LSB +: 4] != 4'hF
                     || s_tdata[mseu_pkg::IN_ACTION_LSB +: 4] == 4'hF);
    assign out_we  = m_tdata[mseu_pkg::OUT_WE_BIT];

    // a held result must not change
    `MSEU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one item in flight: input closes right after an acceptance
    `MSEU_ASSERT_NEXT(a_busy_after_accept, in_item, !s_tready, "input ready right after accepting an item")

    // a result never appears the cycle right after an acceptance
    `MSEU_ASSERT_NOW(a_no_instant_result, $rose(m_tvalid), !$past(s_tvalid && s_tready), "result too soon after accept")

    // register zero is never reported as written
    `MSEU_ASSERT_NOW(a_no_zero_write, m_tvalid && out_we, m_tdata[mseu_pkg::OUT_WREG_LSB +: mseu_pkg::REG_AW] != mseu_pkg::ZERO_REG, "write to register zero reported")

    // without a write the register and value fields are cleared
    `MSEU_ASSERT_NOW(a_idle_write_fields, m_tvalid && !out_we, m_tdata[mseu_pkg::OUT_WVAL_LSB +: mseu_pkg::DATA_W] == 32'd0 && m_tdata[mseu_pkg::OUT_WREG_LSB +: mseu_pkg::REG_AW] == mseu_pkg::ZERO_REG, "write fields set without write")

endmodule

bind mips_subset_execute_unit mseu_checker u_mseu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/mips_subset_execute_unit_checker.sv =====
`timescale 1ns / 1ps
// Result checker for mips_subset_execute_unit: watches both stream channels, runs its
// own register file and line counter, and compares each result item with its forecast.
// Depends on mseu_pkg.
module mips_subset_execute_unit_checker
    import mseu_pkg::*;
#(
    parameter int PROGRAM_LINES = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     mismatch_count,
    output int                     pending
);

    typedef struct packed {
        logic [OUT_LINE_W-1:0] next_line;
        logic                  we;
        logic [REG_AW-1:0]     wreg;
        logic [DATA_W-1:0]     wval;
        logic                  taken;
        logic                  dz;
    } exec_result_t;

    logic [DATA_W-1:0]     arch_regs [REG_COUNT];
    logic [OUT_LINE_W-1:0] pc_line;
    exec_result_t          results_due [$];
    int                    results_seen;

    initial
    begin
        foreach (arch_regs[i])
            arch_regs[i] = '0;
        pc_line        = '0;
        mismatch_count = 0;
        pending        = 0;
        results_seen   = 0;
    end

    // Executes one instruction against the shadow state and returns its result item.
    function automatic exec_result_t execute_instr(input logic [IN_TDATA_W-1:0] word);
        logic [3:0]            act;
        logic [REG_AW-1:0]     rd;
        logic [DATA_W-1:0]     va, vb, vd, imm, mag_a, mag_b, quot;
        logic [TARGET_W-1:0]   tgt;
        logic [OUT_LINE_W-1:0] seq_line;
        exec_result_t          r;
        act = word[IN_ACTION_LSB +: 4];
        rd  = word[IN_DEST_LSB +: REG_AW];
        // register zero is never written here, so it always reads 0
        va  = arch_regs[word[IN_SRC_A_LSB +: REG_AW]];
        vb  = arch_regs[word[IN_SRC_B_LSB +: REG_AW]];
        vd  = arch_regs[rd];
        imm = word[IN_IMM_LSB +: DATA_W];
        tgt = word[IN_TARGET_LSB +: TARGET_W];
        seq_line = OUT_LINE_W'((pc_line + 1) % PROGRAM_LINES);

        r = '0;
        r.next_line = seq_line;
        if (act <= ACT_DIV)
        begin
            r.we   = 1'b1;
            r.wreg = rd;
        end
        case (act)
            ACT_ADDI: r.wval = va + imm;
            ACT_SUBI: r.wval = va - imm;
            ACT_ADD:  r.wval = va + vb;
            ACT_SUB:  r.wval = va - vb;
            ACT_MUL:  r.wval = va * vb;
            ACT_DIV:
            begin
                if (vb == '0)
                    r.dz = 1'b1;
                else
                begin
                    // truncate toward zero on magnitudes; min / -1 wraps by itself
                    mag_a  = va[DATA_W-1] ? -va : va;
                    mag_b  = vb[DATA_W-1] ? -vb : vb;
                    quot   = mag_a / mag_b;
                    r.wval = (va[DATA_W-1] != vb[DATA_W-1]) ? -quot : quot;
                end
            end
            ACT_BLT:  r.taken = ($signed(vd) < $signed(va));
            ACT_BGT:  r.taken = ($signed(vd) > $signed(va));
            ACT_BEQ:  r.taken = (vd == va);
            ACT_J:    r.taken = 1'b1;
            ACT_JAL:
            begin
                r.we    = 1'b1;
                r.wreg  = LINK_REG;
                r.wval  = DATA_W'(seq_line);
                r.taken = 1'b1;
            end
            ACT_JR:   r.taken = 1'b1;
            default:  ;
        endcase
        if (r.taken)
            r.next_line = (act == ACT_JR) ? OUT_LINE_W'(vd % PROGRAM_LINES)
                                          : OUT_LINE_W'(tgt % PROGRAM_LINES);

        if (r.we && r.wreg == ZERO_REG)
            r.we = 1'b0;
        if (r.we)
            arch_regs[r.wreg] = r.wval;
        else
        begin
            r.wreg = '0;
            r.wval = '0;
        end
        pc_line = r.next_line;
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        exec_result_t due;
        exec_result_t got;
        if (rst_n)
        begin
            // results first, so a result can never match an item taken on the same edge
            if (m_tvalid && m_tready)
            begin
                got.next_line = m_tdata[OUT_LINE_LSB +: OUT_LINE_W];
                got.we        = m_tdata[OUT_WE_BIT];
                got.wreg      = m_tdata[OUT_WREG_LSB +: REG_AW];
                got.wval      = m_tdata[OUT_WVAL_LSB +: DATA_W];
                got.taken     = m_tdata[OUT_TAKEN_BIT];
                got.dz        = m_tdata[OUT_DZ_BIT];
                if (results_due.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("item %0d: result with nothing outstanding, tdata %h",
                                 results_seen, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    due = results_due.pop_front();
                    if (got.next_line !== due.next_line || got.we !== due.we ||
                        got.wreg !== due.wreg || got.wval !== due.wval ||
                        got.taken !== due.taken || got.dz !== due.dz)
                    begin
                        if (mismatch_count < 10)
                            $display({"item %0d: exp line %0d we %b reg %0d val %h tk %b dz %b",
                                      " | got line %0d we %b reg %0d val %h tk %b dz %b"},
                                     results_seen, due.next_line, due.we, due.wreg,
                                     due.wval, due.taken, due.dz, got.next_line, got.we,
                                     got.wreg, got.wval, got.taken, got.dz);
                        mismatch_count++;
                    end
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
                results_due.push_back(execute_instr(s_tdata));
            pending = results_due.size();
        end
    end

endmodule

// ===== bench/mips_subset_execute_unit_test.sv =====
`timescale 1ns / 1ps
// Top of the execute unit bench: clock, reset, instruction stream and result stalls.
// Depends on mseu_pkg, mips_subset_execute_unit and mips_subset_execute_unit_checker.
module mips_subset_execute_unit_test;
    import mseu_pkg::*;

    localparam int RANDOM_ITEMS = 525;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 600000;

    localparam logic [DATA_W-1:0] INT_MAX       = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] INT_MIN       = 32'h8000_0000;
    localparam logic [3:0]        ACT_LAST_CODE = 4'hF;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int pending;
    int cycle_count = 0;
    int stall_left  = 0;
    bit rx_quiet    = 1'b0;
    bit tx_calm     = 1'b0;

    mips_subset_execute_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mips_subset_execute_unit_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_instr(
        input logic [3:0]          act,
        input logic [REG_AW-1:0]   rd, ra, rb,
        input logic [DATA_W-1:0]   imm,
        input logic [TARGET_W-1:0] tgt
    );
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[IN_ACTION_LSB +: 4]        = act;
        word[IN_DEST_LSB +: REG_AW]     = rd;
        word[IN_SRC_A_LSB +: REG_AW]    = ra;
        word[IN_SRC_B_LSB +: REG_AW]    = rb;
        word[IN_IMM_LSB +: DATA_W]      = imm;
        word[IN_TARGET_LSB +: TARGET_W] = tgt;
        return word;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_instr();
        int                  roll;
        logic [3:0]          act;
        logic [REG_AW-1:0]   rd, ra, rb;
        logic [DATA_W-1:0]   imm;
        logic [TARGET_W-1:0] tgt;
        // addi is weighted up so the register file keeps getting fresh values
        roll = $urandom_range(0, 19);
        if (roll < 4)
            act = ACT_ADDI;
        else if (roll < 6)
            act = ACT_DIV;
        else if (roll == 6)
            act = 4'($urandom_range(ACT_JR + 1, ACT_LAST_CODE));
        else
            act = 4'($urandom_range(ACT_ADDI, ACT_JR));
        rd = ($urandom_range(0, 7) == 0) ? ZERO_REG : REG_AW'($urandom_range(1, REG_COUNT - 1));
        ra = ($urandom_range(0, 7) == 0) ? ZERO_REG : REG_AW'($urandom_range(1, REG_COUNT - 1));
        rb = ($urandom_range(0, 7) == 0) ? ZERO_REG : REG_AW'($urandom_range(1, REG_COUNT - 1));
        // same register on both sides makes equal compares common
        if ($urandom_range(0, 5) == 0)
            ra = rd;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            case ($urandom_range(0, 4))
                0:       imm = '0;
                1:       imm = 32'd1;
                2:       imm = '1;
                3:       imm = INT_MIN;
                default: imm = INT_MAX;
            endcase
        else if (roll < 6)
            imm = DATA_W'($urandom_range(0, 64)) - 32'd32;
        else
            imm = $urandom;
        roll = $urandom_range(0, 7);
        tgt = (roll == 0) ? '0 : (roll == 1) ? '1 : TARGET_W'($urandom);
        return pack_instr(act, rd, ra, rb, imm, tgt);
    endfunction

    // entered at a rising edge; returns at the edge where the item is taken
    task automatic send_item(input logic [IN_TDATA_W-1:0] word);
        int gap;
        gap = tx_calm ? 0 : idle_len();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // result side back-pressure, with quiet stretches of full readiness
    always @(posedge clk)
    begin
        int stall;
        if (rst_n)
        begin
            if ($urandom_range(0, 299) == 0)
                rx_quiet <= ~rx_quiet;
            if (stall_left != 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                stall = rx_quiet ? 0 : idle_len();
                m_tready   <= (stall == 0);
                stall_left <= (stall == 0) ? 0 : stall - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes into registers, then wraparound on each arithmetic kind
        send_item(pack_instr(ACT_ADDI, 5'd1, ZERO_REG, ZERO_REG, INT_MAX, '0));
        send_item(pack_instr(ACT_ADDI, 5'd2, ZERO_REG, ZERO_REG, INT_MIN, '0));
        send_item(pack_instr(ACT_SUBI, 5'd3, ZERO_REG, ZERO_REG, 32'd1, '0));
        send_item(pack_instr(ACT_ADDI, 5'd4, 5'd1, ZERO_REG, 32'd1, '0));
        send_item(pack_instr(ACT_SUBI, 5'd5, 5'd2, ZERO_REG, 32'd1, '0));
        send_item(pack_instr(ACT_ADD, 5'd6, 5'd1, 5'd1, '0, '0));
        send_item(pack_instr(ACT_SUB, 5'd7, 5'd2, 5'd1, '0, '0));
        send_item(pack_instr(ACT_MUL, 5'd8, 5'd1, 5'd3, '0, '0));
        // min / -1, zero divisor, negative operands truncated toward zero
        send_item(pack_instr(ACT_DIV, 5'd10, 5'd2, 5'd3, '0, '0));
        send_item(pack_instr(ACT_DIV, 5'd11, 5'd1, ZERO_REG, '0, '0));
        send_item(pack_instr(ACT_SUBI, 5'd12, ZERO_REG, ZERO_REG, 32'd7, '0));
        send_item(pack_instr(ACT_DIV, 5'd13, 5'd12, 5'd6, '0, '0));
        send_item(pack_instr(ACT_DIV, 5'd14, 5'd1, 5'd12, '0, '0));
        // register zero as destination, plain and with a zero divisor
        send_item(pack_instr(ACT_ADDI, ZERO_REG, 5'd1, ZERO_REG, INT_MIN, '0));
        send_item(pack_instr(ACT_DIV, ZERO_REG, 5'd1, ZERO_REG, '0, '0));
        // branches taken and not taken
        send_item(pack_instr(ACT_BLT, 5'd2, 5'd1, ZERO_REG, '0, '0));
        send_item(pack_instr(ACT_BLT, 5'd1, 5'd2, ZERO_REG, '0, '1));
        send_item(pack_instr(ACT_BEQ, 5'd1, 5'd4, ZERO_REG, '0, '1));
        send_item(pack_instr(ACT_BGT, 5'd1, 5'd2, ZERO_REG, '0, '1));
        // at the top line: link wraps to 0, then sequential advance wraps
        send_item(pack_instr(ACT_JAL, 5'd9, 5'd9, ZERO_REG, '0, 10'd512));
        send_item(pack_instr(ACT_BEQ, ZERO_REG, LINK_REG, ZERO_REG, '0, '1));
        send_item(pack_instr(ACT_ADDI, 5'd15, ZERO_REG, ZERO_REG, '0, '0));
        send_item(pack_instr(ACT_J, ZERO_REG, ZERO_REG, ZERO_REG, '0, '1));
        // jr on an all-ones register wraps into range; jr on the link of 0
        send_item(pack_instr(ACT_JR, 5'd3, ZERO_REG, ZERO_REG, '0, '0));
        send_item(pack_instr(ACT_JR, LINK_REG, ZERO_REG, ZERO_REG, '0, '0));
        send_item(pack_instr(ACT_LAST_CODE, 5'd1, 5'd2, 5'd3, INT_MAX, '1));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            send_item(random_instr());
        end
        s_tvalid <= 1'b0;

        // one edge so the checker has counted the last item
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mseu_pkg.sv
rtl/core/mips_subset_execute_unit.sv
rtl/core/mseu_checker.sv
bench/mips_subset_execute_unit_checker.sv
bench/mips_subset_execute_unit_test.sv
